@@ sv/mifd_pkg.sv @@
// Shared types, constants and the copy-offset table for the MAG flag decoder.
// No dependencies; every other file imports this package.
package mifd_pkg;

  localparam int unsigned ROWS_MAX   = 1024;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [7:0]  LINE_BYTES_RST = 8'd80;
  localparam logic [10:0] LINE_COUNT_RST = 11'd400;

  typedef enum logic [0:0] {
    REG_LINE_BYTES = 1'b0,
    REG_LINE_COUNT = 1'b1
  } cfg_reg_t;

  // copy distance = dx + (has_dy ? line width << dy_sh : 0)
  typedef struct packed {
    logic [2:0] dx;
    logic       has_dy;
    logic [2:0] dy_sh;
  } back_t;

  typedef struct packed {
    logic busy;
    logic line_end;
    logic frame_end;
  } pos_status_t;

  function automatic back_t back_lookup(input logic [3:0] nib);
    back_t b;
    unique case (nib)
      4'd0:  b = '{dx: 3'd0, has_dy: 1'b0, dy_sh: 3'd0};
      4'd1:  b = '{dx: 3'd1, has_dy: 1'b0, dy_sh: 3'd0};
      4'd2:  b = '{dx: 3'd2, has_dy: 1'b0, dy_sh: 3'd0};
      4'd3:  b = '{dx: 3'd4, has_dy: 1'b0, dy_sh: 3'd0};
      4'd4:  b = '{dx: 3'd0, has_dy: 1'b1, dy_sh: 3'd0};
      4'd5:  b = '{dx: 3'd1, has_dy: 1'b1, dy_sh: 3'd0};
      4'd6:  b = '{dx: 3'd0, has_dy: 1'b1, dy_sh: 3'd1};
      4'd7:  b = '{dx: 3'd1, has_dy: 1'b1, dy_sh: 3'd1};
      4'd8:  b = '{dx: 3'd2, has_dy: 1'b1, dy_sh: 3'd1};
      4'd9:  b = '{dx: 3'd0, has_dy: 1'b1, dy_sh: 3'd2};
      4'd10: b = '{dx: 3'd1, has_dy: 1'b1, dy_sh: 3'd2};
      4'd11: b = '{dx: 3'd2, has_dy: 1'b1, dy_sh: 3'd2};
      4'd12: b = '{dx: 3'd0, has_dy: 1'b1, dy_sh: 3'd3};
      4'd13: b = '{dx: 3'd1, has_dy: 1'b1, dy_sh: 3'd3};
      4'd14: b = '{dx: 3'd2, has_dy: 1'b1, dy_sh: 3'd3};
      4'd15: b = '{dx: 3'd0, has_dy: 1'b1, dy_sh: 3'd4};
      default: b = '{dx: 3'd0, has_dy: 1'b0, dy_sh: 3'd0};
    endcase
    return b;
  endfunction

endpackage

@@ sv/mifd_if.sv @@
// Handshake channels of the MAG flag decoder: flag/literal input words and
// decoded group-pair result words. Depends on mifd_pkg.
interface mifd_in_if;
  logic        valid;
  logic        ready;
  logic        flag_a_bit;
  logic [7:0]  flag_b_byte;
  logic [15:0] first_pixel_word;
  logic [15:0] second_pixel_word;

  modport source (output valid, flag_a_bit, flag_b_byte, first_pixel_word,
                  second_pixel_word, input ready);
  modport sink (input valid, flag_a_bit, flag_b_byte, first_pixel_word,
                second_pixel_word, output ready);
endinterface

interface mifd_out_if import mifd_pkg::*; #(parameter int unsigned COL_W = 7);
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] column_pair;
  logic [15:0]      left_group;
  logic [15:0]      right_group;
  logic             flag_b_used;
  logic [1:0]       pixel_words_used;
  logic             frame_done;

  modport source (output valid, row, column_pair, left_group, right_group,
                  flag_b_used, pixel_words_used, frame_done, input ready);
  modport sink (input valid, row, column_pair, left_group, right_group,
                flag_b_used, pixel_words_used, frame_done, output ready);
endinterface

@@ sv/mifd_pos.sv @@
// Position tracking: config registers, column/row counters and the linear
// group address of the current line (true and modulo history depth).
// Depends on mifd_pkg.
module mifd_pos import mifd_pkg::*; #(
  parameter  int unsigned MAX_LINE_BYTES = 128,
  parameter  int unsigned HISTORY_LINES  = 17,
  localparam int unsigned CW             = $clog2(MAX_LINE_BYTES),
  localparam int unsigned LBW            = ($clog2(MAX_LINE_BYTES + 1) > 8) ?
                                           $clog2(MAX_LINE_BYTES + 1) : 8,
  localparam int unsigned HIST_DEPTH     = HISTORY_LINES * 2 * MAX_LINE_BYTES,
  localparam int unsigned MW             = $clog2(HIST_DEPTH),
  localparam int unsigned LW             = $clog2(ROWS_MAX * 2 * MAX_LINE_BYTES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  cfg_wr_en,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [CW-1:0]         col,
  output logic [ROW_W-1:0]      row,
  output logic [LW-1:0]         lin,
  output logic [MW-1:0]         lin_mod,
  output logic [LBW:0]          width,
  output pos_status_t           status
);

  logic [7:0]       line_bytes;
  logic [10:0]      line_count;
  logic [MW-1:0]    row_base;     // row * width mod history depth
  logic [LW-1:0]    row_lin;      // row * width
  logic             rebasing;
  logic [ROW_W-1:0] rb_cnt;

  logic [LBW-1:0] lb_ext;
  logic [LBW-1:0] eff_lb;
  logic [10:0]    eff_lc;
  logic [CW:0]    two_col;
  logic [MW:0]    mod_sum;
  logic [MW:0]    base_sum;
  logic [MW-1:0]  base_step;
  logic           line_end;
  logic           frame_end;

  always_comb begin
    lb_ext = LBW'(line_bytes);
    if (line_bytes == 8'd0) begin
      eff_lb = LBW'(1);
    end else if (lb_ext > LBW'(MAX_LINE_BYTES)) begin
      eff_lb = LBW'(MAX_LINE_BYTES);
    end else begin
      eff_lb = lb_ext;
    end

    if (line_count == 11'd0) begin
      eff_lc = 11'd1;
    end else if (line_count > 11'(ROWS_MAX)) begin
      eff_lc = 11'(ROWS_MAX);
    end else begin
      eff_lc = line_count;
    end

    width   = {eff_lb, 1'b0};
    two_col = {col, 1'b0};

    mod_sum = (MW+1)'(row_base) + (MW+1)'(two_col);
    lin_mod = (mod_sum >= (MW+1)'(HIST_DEPTH)) ?
              MW'(mod_sum - (MW+1)'(HIST_DEPTH)) : MW'(mod_sum);
    lin     = row_lin + LW'(two_col);

    base_sum  = (MW+1)'(row_base) + (MW+1)'(width);
    base_step = (base_sum >= (MW+1)'(HIST_DEPTH)) ?
                MW'(base_sum - (MW+1)'(HIST_DEPTH)) : MW'(base_sum);

    line_end  = (LBW'(col) + LBW'(1)) >= eff_lb;
    frame_end = line_end && ((11'(row) + 11'd1) >= eff_lc);

    status.busy      = rebasing;
    status.line_end  = line_end;
    status.frame_end = frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes <= LINE_BYTES_RST;
      line_count <= LINE_COUNT_RST;
      col        <= '0;
      row        <= '0;
      row_base   <= '0;
      row_lin    <= '0;
      rebasing   <= 1'b0;
      rb_cnt     <= '0;
    end else begin
      if (adv) begin
        if (frame_end) begin
          col      <= '0;
          row      <= '0;
          row_base <= '0;
          row_lin  <= '0;
        end else if (line_end) begin
          col      <= '0;
          row      <= row + ROW_W'(1);
          row_base <= base_step;
          row_lin  <= row_lin + LW'(width);
        end else begin
          col <= col + CW'(1);
        end
      end

      // rebuild row * width after a width change, one line per cycle
      if (rebasing) begin
        if (rb_cnt == row) begin
          rebasing <= 1'b0;
        end else begin
          row_base <= base_step;
          row_lin  <= row_lin + LW'(width);
          rb_cnt   <= rb_cnt + ROW_W'(1);
        end
      end

      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_LINE_BYTES: begin
            line_bytes <= cfg_data[7:0];
            rebasing   <= 1'b1;
            rb_cnt     <= '0;
            row_base   <= '0;
            row_lin    <= '0;
          end
          REG_LINE_COUNT: line_count <= cfg_data;
        endcase
      end
    end
  end

endmodule

@@ sv/mifd_flag_store.sv @@
// Previous-line flag bytes: one entry per column with valid bits that a frame
// end clears, plus forwarding of the last write. Depends on mifd_pkg.
module mifd_flag_store import mifd_pkg::*; #(
  parameter  int unsigned DEPTH = 128,
  localparam int unsigned CW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [CW-1:0] rd_col,
  input  logic          wr_en,
  input  logic [CW-1:0] wr_col,
  input  logic [7:0]    wr_data,
  input  logic          wr_clear,
  output logic [7:0]    rd_data
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [7:0]       rd_q;
  logic             rd_vq;
  logic [CW-1:0]    rd_col_q;
  logic             rec_v;
  logic             rec_clear;
  logic [CW-1:0]    rec_col;
  logic [7:0]       rec_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_col] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_col];
      rd_col_q <= rd_col;
    end
    if (wr_en) begin
      rec_col  <= wr_col;
      rec_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      rd_vq     <= 1'b0;
      rec_v     <= 1'b0;
      rec_clear <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vq <= vld[rd_col];
      end
      if (wr_en) begin
        rec_v     <= 1'b1;
        rec_clear <= wr_clear;
        if (wr_clear) begin
          vld <= '0;
        end else begin
          vld[wr_col] <= 1'b1;
        end
      end
    end
  end

  // the write that lands on the same edge as the read is not in rd_q yet
  always_comb begin
    if (rec_clear) begin
      rd_data = 8'h00;
    end else if (rec_v && (rec_col == rd_col_q)) begin
      rd_data = rec_data;
    end else if (rd_vq) begin
      rd_data = rd_q;
    end else begin
      rd_data = 8'h00;
    end
  end

endmodule

@@ sv/mifd_hist_bank.sv @@
// One bank of the group history: one write port, two registered read ports.
// Depends on mifd_pkg only for the common import.
module mifd_hist_bank import mifd_pkg::*; #(
  parameter  int unsigned DEPTH = 2176,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [15:0]   rdata0,
  output logic [15:0]   rdata1
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

@@ sv/mag_image_flag_decoder.sv @@
// MAG flag decoder top level. Depends on mifd_pkg, mifd_if, mifd_pos,
// mifd_flag_store and mifd_hist_bank.
//
// Takes one flag word per clock while ready is high and returns one group-pair
// word after the flag read, history read and output register; throughput is
// one word per clock unless the output stalls, set by the history being split
// into an even-group bank and an odd-group bank, each with one write port and
// two read ports. After reset the history is swept to zero, all
// HISTORY_LINES * MAX_LINE_BYTES entries of each bank (2176 by default), with
// ready low; configuration writes are taken during the sweep. A write of
// line_bytes recomputes the line base address, stepping once per completed
// line of the current frame, again with ready low.
module mag_image_flag_decoder import mifd_pkg::*; #(
  parameter int unsigned MAX_LINE_BYTES = 128,
  parameter int unsigned HISTORY_LINES  = 17
) (
  input  logic                  clk,
  input  logic                  rst,
  mifd_in_if.sink               flags,
  mifd_out_if.source            groups,
  input  logic                  cfg_wr_en,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CW = $clog2(MAX_LINE_BYTES);
  localparam int unsigned LBW = ($clog2(MAX_LINE_BYTES + 1) > 8) ?
                                $clog2(MAX_LINE_BYTES + 1) : 8;
  localparam int unsigned HIST_DEPTH = HISTORY_LINES * 2 * MAX_LINE_BYTES;
  localparam int unsigned BANK_DEPTH = HISTORY_LINES * MAX_LINE_BYTES;
  localparam int unsigned MW = $clog2(HIST_DEPTH);
  localparam int unsigned IW = $clog2(BANK_DEPTH);
  localparam int unsigned LW = $clog2(ROWS_MAX * 2 * MAX_LINE_BYTES);

  // position
  logic [CW-1:0]    p_col;
  logic [ROW_W-1:0] p_row;
  logic [LW-1:0]    p_lin;
  logic [MW-1:0]    p_mod;
  logic [LBW:0]     p_width;
  pos_status_t      p_st;

  logic accept;
  logic s1_adv;
  logic s2_adv;

  // history clear sweep
  logic          clearing;
  logic [IW-1:0] clr_idx;

  // stage 1: flag byte
  logic             s1_v;
  logic [CW-1:0]    s1_col;
  logic [ROW_W-1:0] s1_row;
  logic [LW-1:0]    s1_lin;
  logic [MW-1:0]    s1_mod;
  logic             s1_a;
  logic [7:0]       s1_b;
  logic [15:0]      s1_w0;
  logic [15:0]      s1_w1;
  logic             s1_done;
  logic [7:0]       s1_old;
  logic [7:0]       s1_flag;
  logic [3:0]       nib   [2];
  back_t            bk    [2];
  logic [MW-1:0]    back  [2];
  logic [LW-1:0]    g_lin [2];
  logic [MW-1:0]    g_mod [2];
  logic [MW-1:0]    src   [2];
  logic             zero  [2];
  logic             lit   [2];
  logic             self1;

  // stage 2: history data
  logic             s2_v;
  logic [CW-1:0]    s2_col;
  logic [ROW_W-1:0] s2_row;
  logic             s2_a;
  logic [15:0]      s2_w0;
  logic [15:0]      s2_w1;
  logic             s2_done;
  logic             s2_lit  [2];
  logic             s2_zero [2];
  logic             s2_par  [2];
  logic [IW-1:0]    s2_sidx [2];
  logic             s2_self1;
  logic [IW-1:0]    s2_own;
  logic [15:0]      b0_q    [2];
  logic [15:0]      b1_q    [2];
  logic [15:0]      hist    [2];
  logic [15:0]      left;
  logic [15:0]      right;

  // last history write, for the read that shared its edge
  logic          rec_v;
  logic [IW-1:0] rec_idx;
  logic [15:0]   rec_l;
  logic [15:0]   rec_r;

  // history write port
  logic          hw_en;
  logic [IW-1:0] hw_idx;
  logic [15:0]   hw_l;
  logic [15:0]   hw_r;

  logic out_v;

  assign s2_adv = s2_v && (!out_v || groups.ready);
  assign s1_adv = s1_v && (!s2_v || s2_adv);
  assign flags.ready = !clearing && !p_st.busy && (!s1_v || s1_adv);
  assign accept = flags.valid && flags.ready;

  mifd_pos #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES),
    .HISTORY_LINES  (HISTORY_LINES)
  ) u_pos (
    .clk       (clk),
    .rst       (rst),
    .adv       (accept),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .col       (p_col),
    .row       (p_row),
    .lin       (p_lin),
    .lin_mod   (p_mod),
    .width     (p_width),
    .status    (p_st)
  );

  mifd_flag_store #(
    .DEPTH (MAX_LINE_BYTES)
  ) u_flag (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_col   (p_col),
    .wr_en    (s1_adv),
    .wr_col   (s1_col),
    .wr_data  (s1_flag),
    .wr_clear (s1_done),
    .rd_data  (s1_old)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == IW'(BANK_DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_idx <= clr_idx + IW'(1);
      end
    end
  end

  // stage 1 entry
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col  <= p_col;
      s1_row  <= p_row;
      s1_lin  <= p_lin;
      s1_mod  <= p_mod;
      s1_a    <= flags.flag_a_bit;
      s1_b    <= flags.flag_b_byte;
      s1_w0   <= flags.first_pixel_word;
      s1_w1   <= flags.second_pixel_word;
      s1_done <= p_st.frame_end;
    end
  end

  // flag byte and copy source addresses of both groups
  always_comb begin
    s1_flag = s1_old ^ (s1_a ? s1_b : 8'h00);
    nib[0]  = s1_flag[7:4];
    nib[1]  = s1_flag[3:0];
    for (int g = 0; g < 2; g++) begin
      bk[g]    = back_lookup(nib[g]);
      back[g]  = MW'(bk[g].dx) +
                 (bk[g].has_dy ? (MW'(p_width) << bk[g].dy_sh) : MW'(0));
      g_lin[g] = s1_lin | LW'(g);
      g_mod[g] = s1_mod | MW'(g);
      zero[g]  = LW'(back[g]) > g_lin[g];
      if (g_mod[g] >= back[g]) begin
        src[g] = g_mod[g] - back[g];
      end else begin
        src[g] = MW'((MW+1)'(g_mod[g]) + (MW+1)'(HIST_DEPTH) - (MW+1)'(back[g]));
      end
      lit[g] = nib[g] == 4'd0;
    end
    self1 = src[1] == s1_mod;
  end

  mifd_hist_bank #(
    .DEPTH (BANK_DEPTH)
  ) u_bank_even (
    .clk    (clk),
    .we     (hw_en),
    .waddr  (hw_idx),
    .wdata  (hw_l),
    .re     (s1_adv),
    .raddr0 (src[0][MW-1:1]),
    .raddr1 (src[1][MW-1:1]),
    .rdata0 (b0_q[0]),
    .rdata1 (b0_q[1])
  );

  mifd_hist_bank #(
    .DEPTH (BANK_DEPTH)
  ) u_bank_odd (
    .clk    (clk),
    .we     (hw_en),
    .waddr  (hw_idx),
    .wdata  (hw_r),
    .re     (s1_adv),
    .raddr0 (src[0][MW-1:1]),
    .raddr1 (src[1][MW-1:1]),
    .rdata0 (b1_q[0]),
    .rdata1 (b1_q[1])
  );

  // stage 2 entry
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_col   <= s1_col;
      s2_row   <= s1_row;
      s2_a     <= s1_a;
      s2_w0    <= s1_w0;
      s2_w1    <= s1_w1;
      s2_done  <= s1_done;
      s2_self1 <= self1;
      s2_own   <= s1_mod[MW-1:1];
      for (int g = 0; g < 2; g++) begin
        s2_lit[g]  <= lit[g];
        s2_zero[g] <= zero[g];
        s2_par[g]  <= src[g][0];
        s2_sidx[g] <= src[g][MW-1:1];
      end
    end
  end

  always_comb begin
    for (int g = 0; g < 2; g++) begin
      if (rec_v && (rec_idx == s2_sidx[g])) begin
        hist[g] = s2_par[g] ? rec_r : rec_l;
      end else begin
        hist[g] = s2_par[g] ? b1_q[g] : b0_q[g];
      end
    end

    if (s2_lit[0]) begin
      left = s2_w0;
    end else if (s2_zero[0]) begin
      left = 16'h0000;
    end else begin
      left = hist[0];
    end

    // right takes the next unused literal; it may copy this word's left group
    if (s2_lit[1]) begin
      right = s2_lit[0] ? s2_w1 : s2_w0;
    end else if (s2_zero[1]) begin
      right = 16'h0000;
    end else if (s2_self1) begin
      right = left;
    end else begin
      right = hist[1];
    end

    hw_en  = clearing || s2_adv;
    hw_idx = clearing ? clr_idx : s2_own;
    hw_l   = clearing ? 16'h0000 : left;
    hw_r   = clearing ? 16'h0000 : right;
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      rec_idx <= s2_own;
      rec_l   <= left;
      rec_r   <= right;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      groups.row              <= s2_row;
      groups.column_pair      <= s2_col;
      groups.left_group       <= left;
      groups.right_group      <= right;
      groups.flag_b_used      <= s2_a;
      groups.pixel_words_used <= {s2_lit[0] & s2_lit[1], s2_lit[0] ^ s2_lit[1]};
      groups.frame_done       <= s2_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      out_v <= 1'b0;
      rec_v <= 1'b0;
    end else begin
      if (accept) begin
        s1_v <= 1'b1;
      end else if (s1_adv) begin
        s1_v <= 1'b0;
      end
      if (s1_adv) begin
        s2_v <= 1'b1;
      end else if (s2_adv) begin
        s2_v <= 1'b0;
      end
      if (s2_adv) begin
        out_v <= 1'b1;
        rec_v <= 1'b1;
      end else if (groups.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  assign groups.valid = out_v;

endmodule
